FILE: hdl/vn_pkg.sv
// Shared types for the vector2_normalize pipeline.
// Used by the square root stage, the divider stage and the top level.
package vn_pkg;

	localparam int unsigned IN_W = 32;
	localparam int unsigned SUM_W = 64;
	localparam int unsigned ROOT_W = 32;
	localparam int unsigned Q_W = 17;
	localparam int unsigned UNIT_W = 18;
	localparam int unsigned UNIT_FRAC = 16;
	localparam int unsigned DIV_W = IN_W + UNIT_FRAC + 1;

	typedef struct packed {
		logic              valid;
		logic [SUM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [IN_W-1:0]   mx;
		logic [IN_W-1:0]   my;
		logic              nx;
		logic              ny;
	} sqrt_item_t;

	typedef struct packed {
		logic              valid;
		logic [ROOT_W-1:0] len;
		logic [DIV_W-1:0]  rx;
		logic [DIV_W-1:0]  ry;
		logic [Q_W-1:0]    qx;
		logic [Q_W-1:0]    qy;
		logic              nx;
		logic              ny;
	} div_item_t;

endpackage

FILE: hdl/vector2_normalize.sv
// Top level of the 2D vector normalizer: length and unit vector of a Q16.16 vector.
// Depends on vn_pkg, vn_sqrt_stage and vn_div_stage.
//
// The block takes one vector in every cycle and never raises busy. Each result
// appears on done for one cycle, after its vector has passed through all stages:
// three stages form the magnitudes, squares and sum, 32 stages settle one root
// bit each, 17 stages settle one quotient bit each for both components, and one
// stage applies the signs. The receiver cannot stall the block.
module vector2_normalize (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [31:0]        vec_x,
	input  logic signed [31:0]        vec_y,
	output logic                      done,
	output logic        [31:0]        length,
	output logic signed [17:0]        unit_x,
	output logic signed [17:0]        unit_y,
	output logic                      zero_vector
);

	localparam int unsigned NSQ = vn_pkg::ROOT_W;
	localparam int unsigned NDV = vn_pkg::Q_W;

	logic                     v_s1, v_s2;
	logic [vn_pkg::IN_W-1:0]  mx_s1, my_s1, mx_s2, my_s2;
	logic                     nx_s1, ny_s1, nx_s2, ny_s2;
	logic [vn_pkg::SUM_W-1:0] sqx_s2, sqy_s2;

	vn_pkg::sqrt_item_t sq [NSQ+1];
	vn_pkg::div_item_t  dv [NDV+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			nx_s1  <= 1'b0;
			ny_s1  <= 1'b0;
			mx_s1  <= '0;
			my_s1  <= '0;
			nx_s2  <= 1'b0;
			ny_s2  <= 1'b0;
			mx_s2  <= '0;
			my_s2  <= '0;
			sqx_s2 <= '0;
			sqy_s2 <= '0;
			sq[0]  <= '0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			nx_s1  <= vec_x[31];
			ny_s1  <= vec_y[31];
			mx_s1  <= vec_x[31] ? 32'(-vec_x) : 32'(vec_x);
			my_s1  <= vec_y[31] ? 32'(-vec_y) : 32'(vec_y);
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			mx_s2  <= mx_s1;
			my_s2  <= my_s1;
			sqx_s2 <= {32'd0, mx_s1} * {32'd0, mx_s1};
			sqy_s2 <= {32'd0, my_s1} * {32'd0, my_s1};
			sq[0].valid <= v_s2;
			sq[0].rem   <= sqx_s2 + sqy_s2;
			sq[0].root  <= '0;
			sq[0].mx    <= mx_s2;
			sq[0].my    <= my_s2;
			sq[0].nx    <= nx_s2;
			sq[0].ny    <= ny_s2;
		end
	end

	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		vn_sqrt_stage #(.IDX(NSQ - 1 - i)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (sq[i]),
			.dout   (sq[i+1])
		);
	end

	assign dv[0].valid = sq[NSQ].valid;
	assign dv[0].len   = sq[NSQ].root;
	assign dv[0].rx    = {1'b0, sq[NSQ].mx, {vn_pkg::UNIT_FRAC{1'b0}}};
	assign dv[0].ry    = {1'b0, sq[NSQ].my, {vn_pkg::UNIT_FRAC{1'b0}}};
	assign dv[0].qx    = '0;
	assign dv[0].qy    = '0;
	assign dv[0].nx    = sq[NSQ].nx;
	assign dv[0].ny    = sq[NSQ].ny;

	for (genvar i = 0; i < NDV; i++) begin : g_div
		vn_div_stage #(.IDX(NDV - 1 - i)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (dv[i]),
			.dout   (dv[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv[NDV].valid;
		end
	end

	always_ff @(posedge clk) begin
		length      <= dv[NDV].len;
		zero_vector <= dv[NDV].len == '0;
		if (dv[NDV].len == '0) begin
			unit_x <= '0;
			unit_y <= '0;
		end else begin
			unit_x <= dv[NDV].nx ? -$signed({1'b0, dv[NDV].qx}) : $signed({1'b0, dv[NDV].qx});
			unit_y <= dv[NDV].ny ? -$signed({1'b0, dv[NDV].qy}) : $signed({1'b0, dv[NDV].qy});
		end
	end

endmodule

FILE: hdl/vn_sqrt_stage.sv
// One registered step of the digit-by-digit square root: decides root bit IDX.
// Depends on vn_pkg.
module vn_sqrt_stage #(
	parameter int unsigned IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vn_pkg::sqrt_item_t din,
	output vn_pkg::sqrt_item_t dout
);

	logic [vn_pkg::SUM_W+1:0] trial;
	logic                     take;

	assign trial = ({{(vn_pkg::SUM_W+2-vn_pkg::ROOT_W){1'b0}}, din.root} << (IDX + 1))
		+ ({{(vn_pkg::SUM_W+1){1'b0}}, 1'b1} << (2 * IDX));
	assign take = {2'b00, din.rem} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.mx    <= din.mx;
			dout.my    <= din.my;
			dout.nx    <= din.nx;
			dout.ny    <= din.ny;
			if (take) begin
				dout.rem  <= din.rem - trial[vn_pkg::SUM_W-1:0];
				dout.root <= din.root | (vn_pkg::ROOT_W'(1) << IDX);
			end else begin
				dout.rem  <= din.rem;
				dout.root <= din.root;
			end
		end
	end

endmodule

FILE: hdl/vn_div_stage.sv
// One registered step of two restoring dividers sharing one divisor: quotient bit IDX.
// Depends on vn_pkg.
module vn_div_stage #(
	parameter int unsigned IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vn_pkg::div_item_t din,
	output vn_pkg::div_item_t dout
);

	logic [vn_pkg::DIV_W-1:0] dsh;
	logic                     take_x;
	logic                     take_y;

	assign dsh = {{(vn_pkg::DIV_W-vn_pkg::ROOT_W){1'b0}}, din.len} << IDX;
	assign take_x = din.rx >= dsh;
	assign take_y = din.ry >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.len   <= din.len;
			dout.nx    <= din.nx;
			dout.ny    <= din.ny;
			dout.rx    <= take_x ? din.rx - dsh : din.rx;
			dout.ry    <= take_y ? din.ry - dsh : din.ry;
			dout.qx    <= din.qx | (take_x ? (vn_pkg::Q_W'(1) << IDX) : '0);
			dout.qy    <= din.qy | (take_y ? (vn_pkg::Q_W'(1) << IDX) : '0);
		end
	end

endmodule
